// ===== src/fdc_pkg.sv =====
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types, constants and the CRC16 byte step for the frame decoder.
// ----------------------------------------------------------------------------
package fdc_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int PAW         = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int HDR_SIZE    = 12;

	localparam logic [PAW-1:0] PAW_ONE = PAW'(1);

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_MSB  = 16'h8000;

	localparam logic [7:0] TYPE_MIN = 8'd1;
	localparam logic [7:0] TYPE_MAX = 8'd6;

	typedef enum logic [2:0] {
		STAT_OK,
		STAT_SHORT_HDR,
		STAT_MAGIC,
		STAT_VERSION,
		STAT_TYPE,
		STAT_LENGTH,
		STAT_SHORT_PAY,
		STAT_CRC
	} stat_t;

	typedef enum logic [1:0] {
		REG_MAGIC,
		REG_VERSION,
		REG_MAXLEN
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FSM_RECV,
		FSM_CHECK,
		FSM_READ,
		FSM_EMIT
	} fsm_t;

	typedef struct packed {
		logic capture;
		logic clear;
		logic load_single;
		logic load_payload;
		logic rd_inc;
	} dp_cmd_t;

	typedef struct packed {
		stat_t chk_status;
		logic  len_zero;
		logic  rd_last;
		logic  out_free;
	} dp_sts_t;

	typedef struct packed {
		logic        we;
		logic [1:0]  index;
		logic [15:0] data;
	} cfg_wr_t;

	typedef struct packed {
		stat_t       status;
		logic [2:0]  msg_type;
		logic [31:0] sequence_res;
		logic [5:0]  pay_len;
		logic [5:0]  frame_total;
		logic [7:0]  payload_byte;
		logic        run_last;
	} result_t;

	// CCITT-FALSE, MSB first, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== src/fdc_if.sv =====
// ----------------------------------------------------------------------------
// fdc_if
// Valid/ready channels of the frame decoder: input bytes, results, config.
// ----------------------------------------------------------------------------
interface fdc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       buffer_end;

	modport source (output valid, output data_byte, output buffer_end, input ready);
	modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface fdc_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [2:0]  msg_type;
	logic [31:0] sequence_res;
	logic [5:0]  pay_len;
	logic [5:0]  frame_total;
	logic [7:0]  payload_byte;
	logic        run_last;

	modport source (output valid, output status, output msg_type, output sequence_res,
		output pay_len, output frame_total, output payload_byte,
		output run_last, input ready);
	modport sink   (input valid, input status, input msg_type, input sequence_res,
		input pay_len, input frame_total, input payload_byte,
		input run_last, output ready);
endinterface

interface fdc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/fdc_dp.sv =====
// ----------------------------------------------------------------------------
// fdc_dp
// Datapath: config registers, header capture, CRC, payload RAM, result register.
// ----------------------------------------------------------------------------
module fdc_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  fdc_pkg::dp_cmd_t  cmd,
	input  logic [7:0]        data_byte,
	input  fdc_pkg::cfg_wr_t  cfg_wr,
	output fdc_pkg::dp_sts_t  sts,
	input  logic              res_ready,
	output logic              res_valid,
	output fdc_pkg::result_t  res_data
);

	logic [15:0] cfg_magic_q;
	logic [7:0]  cfg_version_q;
	logic [5:0]  cfg_maxlen_q;

	logic [15:0] byte_count_q;
	logic [15:0] hdr_magic_q;
	logic [7:0]  hdr_version_q;
	logic [7:0]  hdr_type_q;
	logic [15:0] hdr_length_q;
	logic [31:0] hdr_sequence_q;
	logic [15:0] hdr_crc_q;
	logic [15:0] crc_q;
	logic [fdc_pkg::PAW-1:0] rd_idx_q;

	logic [7:0] mem [fdc_pkg::MAX_PAYLOAD];
	logic [7:0] rd_data_q;

	logic             out_valid_q;
	fdc_pkg::result_t out_q;

	logic [15:0] pay_off;
	logic        in_hdr;
	logic        in_pay;
	logic        store;
	logic [15:0] limit;
	logic [16:0] need;
	logic [15:0] crc_expect;
	logic        out_free;
	logic        rd_last;
	fdc_pkg::stat_t chk_status;

	always_comb begin
		pay_off    = byte_count_q - 16'(fdc_pkg::HDR_SIZE);
		in_hdr     = byte_count_q < 16'(fdc_pkg::HDR_SIZE);
		in_pay     = !in_hdr && (pay_off < hdr_length_q);
		store      = in_pay && (pay_off < 16'(fdc_pkg::MAX_PAYLOAD));
		limit      = (16'(cfg_maxlen_q) < 16'(fdc_pkg::MAX_PAYLOAD)) ?
			16'(cfg_maxlen_q) : 16'(fdc_pkg::MAX_PAYLOAD);
		need       = 17'(fdc_pkg::HDR_SIZE) + 17'(hdr_length_q);
		crc_expect = (hdr_length_q != 16'h0000) ? crc_q : 16'h0000;
		out_free   = !out_valid_q || res_ready;
		rd_last    = (17'(rd_idx_q) + 17'd1) == 17'(hdr_length_q);
	end

	always_comb begin
		priority if (in_hdr) begin
			chk_status = fdc_pkg::STAT_SHORT_HDR;
		end else if (hdr_magic_q != cfg_magic_q) begin
			chk_status = fdc_pkg::STAT_MAGIC;
		end else if (hdr_version_q != cfg_version_q) begin
			chk_status = fdc_pkg::STAT_VERSION;
		end else if (hdr_type_q < fdc_pkg::TYPE_MIN || hdr_type_q > fdc_pkg::TYPE_MAX) begin
			chk_status = fdc_pkg::STAT_TYPE;
		end else if (hdr_length_q > limit) begin
			chk_status = fdc_pkg::STAT_LENGTH;
		end else if ({1'b0, byte_count_q} < need) begin
			chk_status = fdc_pkg::STAT_SHORT_PAY;
		end else if (hdr_crc_q != crc_expect) begin
			chk_status = fdc_pkg::STAT_CRC;
		end else begin
			chk_status = fdc_pkg::STAT_OK;
		end
	end

	assign sts.chk_status = chk_status;
	assign sts.len_zero   = hdr_length_q == 16'h0000;
	assign sts.rd_last    = rd_last;
	assign sts.out_free   = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_magic_q   <= 16'h0000;
			cfg_version_q <= 8'h00;
			cfg_maxlen_q  <= 6'd32;
		end else if (cfg_wr.we) begin
			unique case (cfg_wr.index)
				fdc_pkg::REG_MAGIC:   cfg_magic_q   <= cfg_wr.data;
				fdc_pkg::REG_VERSION: cfg_version_q <= cfg_wr.data[7:0];
				fdc_pkg::REG_MAXLEN:  cfg_maxlen_q  <= cfg_wr.data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= 16'h0000;
			hdr_magic_q    <= 16'h0000;
			hdr_version_q  <= 8'h00;
			hdr_type_q     <= 8'h00;
			hdr_length_q   <= 16'h0000;
			hdr_sequence_q <= 32'h0;
			hdr_crc_q      <= 16'h0000;
			crc_q          <= fdc_pkg::CRC_INIT;
			rd_idx_q       <= '0;
		end else if (cmd.clear) begin
			byte_count_q   <= 16'h0000;
			hdr_magic_q    <= 16'h0000;
			hdr_version_q  <= 8'h00;
			hdr_type_q     <= 8'h00;
			hdr_length_q   <= 16'h0000;
			hdr_sequence_q <= 32'h0;
			hdr_crc_q      <= 16'h0000;
			crc_q          <= fdc_pkg::CRC_INIT;
			rd_idx_q       <= '0;
		end else begin
			if (cmd.rd_inc) begin
				rd_idx_q <= rd_idx_q + fdc_pkg::PAW_ONE;
			end
			if (cmd.capture) begin
				if (byte_count_q != 16'hFFFF) begin
					byte_count_q <= byte_count_q + 16'd1;
				end
				if (in_hdr) begin
					unique case (byte_count_q[3:0])
						4'd0:  hdr_magic_q[7:0]      <= data_byte;
						4'd1:  hdr_magic_q[15:8]     <= data_byte;
						4'd2:  hdr_version_q         <= data_byte;
						4'd3:  hdr_type_q            <= data_byte;
						4'd4:  hdr_length_q[7:0]     <= data_byte;
						4'd5:  hdr_length_q[15:8]    <= data_byte;
						4'd6:  hdr_sequence_q[7:0]   <= data_byte;
						4'd7:  hdr_sequence_q[15:8]  <= data_byte;
						4'd8:  hdr_sequence_q[23:16] <= data_byte;
						4'd9:  hdr_sequence_q[31:24] <= data_byte;
						4'd10: hdr_crc_q[7:0]        <= data_byte;
						4'd11: hdr_crc_q[15:8]       <= data_byte;
						default: ;
					endcase
				end else if (in_pay) begin
					crc_q <= fdc_pkg::crc16_byte(crc_q, data_byte);
				end
			end
		end
	end

	// payload RAM, registered read
	always_ff @(posedge clk) begin
		if (cmd.capture && store) begin
			mem[pay_off[fdc_pkg::PAW-1:0]] <= data_byte;
		end
		rd_data_q <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_single || cmd.load_payload) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_single) begin
			out_q.status       <= chk_status;
			out_q.run_last     <= 1'b1;
			out_q.pay_len      <= 6'd0;
			out_q.payload_byte <= 8'h00;
			if (chk_status == fdc_pkg::STAT_OK) begin
				out_q.msg_type     <= hdr_type_q[2:0];
				out_q.sequence_res <= hdr_sequence_q;
				out_q.frame_total  <= 6'(fdc_pkg::HDR_SIZE);
			end else begin
				out_q.msg_type     <= 3'd0;
				out_q.sequence_res <= 32'h0;
				out_q.frame_total  <= 6'd0;
			end
		end else if (cmd.load_payload) begin
			out_q.status         <= fdc_pkg::STAT_OK;
			out_q.msg_type       <= hdr_type_q[2:0];
			out_q.sequence_res   <= hdr_sequence_q;
			out_q.pay_len        <= hdr_length_q[5:0];
			out_q.frame_total    <= 6'(16'(fdc_pkg::HDR_SIZE) + hdr_length_q);
			out_q.payload_byte   <= rd_data_q;
			out_q.run_last       <= rd_last;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_single || cmd.load_payload) |-> out_free)
		else $error("result register overwritten");

	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (byte_count_q == 16'h0000 && crc_q == fdc_pkg::CRC_INIT))
		else $error("frame state not cleared");

	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_payload |-> (16'(rd_idx_q) < hdr_length_q))
		else $error("payload read past length");

endmodule

// ===== src/fdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fdc_ctrl
// Controller: receive, check at buffer end, then payload readout.
// ----------------------------------------------------------------------------
module fdc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	input  logic              rx_end,
	output logic              rx_ready,
	input  fdc_pkg::dp_sts_t  sts,
	output fdc_pkg::dp_cmd_t  cmd
);

	fdc_pkg::fsm_t st_q;
	fdc_pkg::fsm_t st_d;

	logic single;

	assign single = (sts.chk_status != fdc_pkg::STAT_OK) || sts.len_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fdc_pkg::FSM_RECV;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			fdc_pkg::FSM_RECV: begin
				if (rx_valid && rx_end) begin
					st_d = fdc_pkg::FSM_CHECK;
				end
			end
			fdc_pkg::FSM_CHECK: begin
				if (!single) begin
					st_d = fdc_pkg::FSM_READ;
				end else if (sts.out_free) begin
					st_d = fdc_pkg::FSM_RECV;
				end
			end
			fdc_pkg::FSM_READ: begin
				st_d = fdc_pkg::FSM_EMIT;
			end
			fdc_pkg::FSM_EMIT: begin
				if (sts.out_free) begin
					st_d = sts.rd_last ? fdc_pkg::FSM_RECV : fdc_pkg::FSM_READ;
				end
			end
			default: st_d = fdc_pkg::FSM_RECV;
		endcase
	end

	always_comb begin
		rx_ready = 1'b0;
		cmd      = '0;
		unique case (st_q)
			fdc_pkg::FSM_RECV: begin
				rx_ready    = 1'b1;
				cmd.capture = rx_valid;
			end
			fdc_pkg::FSM_CHECK: begin
				if (single && sts.out_free) begin
					cmd.load_single = 1'b1;
					cmd.clear       = 1'b1;
				end
			end
			fdc_pkg::FSM_READ: ;
			fdc_pkg::FSM_EMIT: begin
				if (sts.out_free) begin
					cmd.load_payload = 1'b1;
					cmd.clear        = sts.rd_last;
					cmd.rd_inc       = !sts.rd_last;
				end
			end
			default: ;
		endcase
	end

	a_end_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == fdc_pkg::FSM_RECV && rx_valid && rx_end) |=> st_q == fdc_pkg::FSM_CHECK)
		else $error("buffer end not checked");

	a_next_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_inc |=> st_q == fdc_pkg::FSM_READ)
		else $error("readout did not continue");

	a_clear_recv: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> st_q == fdc_pkg::FSM_RECV)
		else $error("clear without return to receive");

endmodule

// ===== src/frame_decoder_crc16_check.sv =====
// ----------------------------------------------------------------------------
// frame_decoder_crc16_check
// Framed packet parser with CRC16-CCITT (init 0xFFFF) payload check.
// ----------------------------------------------------------------------------
// Bytes are accepted one per cycle while a buffer is received. The beat that
// carries buffer_end is followed by a check state; a failed or empty frame then
// gives a single result, and a good frame gives one result per payload byte,
// paced by the registered read of the payload RAM feeding the result register
// and held while the output stalls. No byte is taken from the time buffer_end
// is accepted until the final result of that buffer is in the result register;
// that result may still wait on the output while the next buffer streams in.
// Configuration writes are taken every cycle and should only happen when idle.
// ----------------------------------------------------------------------------
module frame_decoder_crc16_check (
	input  logic         clk,
	input  logic         arst_n,
	fdc_byte_if.sink     rx,
	fdc_res_if.source    res,
	fdc_cfg_if.sink      cfg
);

	fdc_pkg::dp_cmd_t cmd;
	fdc_pkg::dp_sts_t sts;
	fdc_pkg::cfg_wr_t cfg_wr;
	fdc_pkg::result_t res_data;
	logic             res_valid;
	logic             rx_ready;

	assign cfg.ready    = 1'b1;
	assign cfg_wr.we    = cfg.valid;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data  = cfg.data;

	assign rx.ready = rx_ready;

	fdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_end   (rx.buffer_end),
		.rx_ready (rx_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fdc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (rx.data_byte),
		.cfg_wr    (cfg_wr),
		.sts       (sts),
		.res_ready (res.ready),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	assign res.valid          = res_valid;
	assign res.status         = res_data.status;
	assign res.msg_type       = res_data.msg_type;
	assign res.sequence_res   = res_data.sequence_res;
	assign res.pay_len        = res_data.pay_len;
	assign res.frame_total    = res_data.frame_total;
	assign res.payload_byte   = res_data.payload_byte;
	assign res.run_last       = res_data.run_last;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for frame_decoder_crc16_check. A short table of bytes
// covers reset values, field extremes and error codes. Random buffers follow
// (good frames, every kind of broken frame and noise) under several register
// settings. Every result beat is compared with an expected beat, taken from the
// table or from a frame parser kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned QUIET_LIMIT   = 1000;
	localparam int unsigned HOLD_CYCLES   = 150;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam logic [1:0]  REG_SPARE     = 2'd3;

	typedef enum int {
		KIND_GOOD,
		KIND_SHORT_HDR,
		KIND_MAGIC,
		KIND_VERSION,
		KIND_TYPE,
		KIND_LENGTH,
		KIND_SHORT_PAY,
		KIND_CRC,
		KIND_NOISE
	} frame_kind_t;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic             buffer_end;
		logic             typed;
		fdc_pkg::result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	fdc_byte_if rx_ch ();
	fdc_res_if  res_ch ();
	fdc_cfg_if  cfg_ch ();

	frame_decoder_crc16_check u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// register copies
	logic [15:0] cfg_magic;
	logic [7:0]  cfg_version;
	logic [5:0]  cfg_maxlen;

	// frame parser state
	logic [15:0] seen_bytes;
	logic [15:0] got_magic;
	logic [7:0]  got_version;
	logic [7:0]  got_type;
	logic [15:0] got_len;
	logic [31:0] got_seq;
	logic [15:0] got_crc;
	logic [15:0] pay_crc;
	logic [7:0]  pay_mem [fdc_pkg::MAX_PAYLOAD];

	fdc_pkg::result_t results_due [$];
	logic [7:0]       frame_bytes [$];
	stim_row_t        directed_rows [$];
	int unsigned      mismatches = 0;
	bit               gaps_on = 1'b0;
	bit               hold_results = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ d[i];
			c = {c[14:0], 1'b0};
			if (fb) c = c ^ fdc_pkg::CRC_POLY;
		end
		return c;
	endfunction

	function automatic void clear_frame_state();
		seen_bytes  = '0;
		got_magic   = '0;
		got_version = '0;
		got_type    = '0;
		got_len     = '0;
		got_seq     = '0;
		got_crc     = '0;
		pay_crc     = fdc_pkg::CRC_INIT;
	endfunction

	// Absorbs one byte; at buffer end queues the frame's results and returns their count.
	function automatic int unsigned decode_byte(input logic [7:0] d, input logic is_end);
		int unsigned      pos, limit, k;
		fdc_pkg::stat_t   st;
		fdc_pkg::result_t r;
		if (seen_bytes < 16'(fdc_pkg::HDR_SIZE)) begin
			unique case (seen_bytes)
				16'd0: got_magic[7:0] = d;
				16'd1: got_magic[15:8] = d;
				16'd2: got_version = d;
				16'd3: got_type = d;
				16'd4: got_len[7:0] = d;
				16'd5: got_len[15:8] = d;
				16'd6, 16'd7, 16'd8, 16'd9: got_seq[8 * (seen_bytes - 16'd6) +: 8] = d;
				16'd10: got_crc[7:0] = d;
				default: got_crc[15:8] = d;
			endcase
		end else begin
			pos = 32'(seen_bytes) - fdc_pkg::HDR_SIZE;
			// payload past the store still feeds the CRC
			if (pos < 32'(got_len)) begin
				pay_crc = crc_step(pay_crc, d);
				if (pos < fdc_pkg::MAX_PAYLOAD) pay_mem[pos] = d;
			end
		end
		if (seen_bytes != 16'hFFFF) seen_bytes = seen_bytes + 16'd1;
		if (!is_end) return 0;

		limit = (32'(cfg_maxlen) < fdc_pkg::MAX_PAYLOAD) ? 32'(cfg_maxlen)
			: fdc_pkg::MAX_PAYLOAD;
		if (seen_bytes < 16'(fdc_pkg::HDR_SIZE)) st = fdc_pkg::STAT_SHORT_HDR;
		else if (got_magic != cfg_magic) st = fdc_pkg::STAT_MAGIC;
		else if (got_version != cfg_version) st = fdc_pkg::STAT_VERSION;
		else if (got_type < fdc_pkg::TYPE_MIN || got_type > fdc_pkg::TYPE_MAX)
			st = fdc_pkg::STAT_TYPE;
		else if (32'(got_len) > limit) st = fdc_pkg::STAT_LENGTH;
		else if (32'(seen_bytes) < fdc_pkg::HDR_SIZE + 32'(got_len))
			st = fdc_pkg::STAT_SHORT_PAY;
		else if (got_crc != ((got_len != 16'd0) ? pay_crc : 16'h0000)) st = fdc_pkg::STAT_CRC;
		else st = fdc_pkg::STAT_OK;

		r = '0;
		r.run_last = 1'b1;
		if (st != fdc_pkg::STAT_OK) begin
			r.status = st;
			results_due.push_back(r);
			k = 1;
		end else if (got_len == 16'd0) begin
			r.msg_type     = got_type[2:0];
			r.sequence_res = got_seq;
			r.frame_total  = 6'(fdc_pkg::HDR_SIZE);
			results_due.push_back(r);
			k = 1;
		end else begin
			for (k = 0; k < 32'(got_len); k++) begin
				r.msg_type     = got_type[2:0];
				r.sequence_res = got_seq;
				r.pay_len      = got_len[5:0];
				r.frame_total  = 6'(fdc_pkg::HDR_SIZE + 32'(got_len));
				r.payload_byte = pay_mem[k];
				r.run_last     = (k + 1 == 32'(got_len));
				results_due.push_back(r);
			end
		end
		clear_frame_state();
		return k;
	endfunction

	function automatic stim_row_t mid_row(input logic [7:0] d);
		stim_row_t s;
		s = '0;
		s.data_byte = d;
		return s;
	endfunction

	function automatic stim_row_t end_row(input logic [7:0] d, input fdc_pkg::result_t want);
		stim_row_t s;
		s.data_byte  = d;
		s.buffer_end = 1'b1;
		s.typed      = 1'b1;
		s.want       = want;
		return s;
	endfunction

	function automatic fdc_pkg::result_t fail_beat(input fdc_pkg::stat_t st);
		fdc_pkg::result_t r;
		r = '0;
		r.status   = st;
		r.run_last = 1'b1;
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t result %s: got %0h expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// ready is sampled at the falling edge, where it has settled
	task automatic push_byte(input logic [7:0] d, input logic is_end);
		logic took;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		rx_ch.valid      <= 1'b1;
		rx_ch.data_byte  <= d;
		rx_ch.buffer_end <= is_end;
		do begin
			@(negedge clk);
			took = rx_ch.ready;
			@(posedge clk);
		end while (took !== 1'b1);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		logic took;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do begin
			@(negedge clk);
			took = cfg_ch.ready;
			@(posedge clk);
		end while (took !== 1'b1);
		unique case (idx)
			fdc_pkg::REG_MAGIC:   cfg_magic = val;
			fdc_pkg::REG_VERSION: cfg_version = val[7:0];
			fdc_pkg::REG_MAXLEN:  cfg_maxlen = val[5:0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every result, then let the block go idle
	task automatic settle();
		rx_ch.valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_frame();
		int unsigned i;
		for (i = 0; i < frame_bytes.size(); i++) begin
			push_byte(frame_bytes[i], i + 1 == frame_bytes.size());
			void'(decode_byte(frame_bytes[i], i + 1 == frame_bytes.size()));
		end
	endtask

	task automatic build_frame();
		int unsigned pick, lim, plen, nbody, i;
		logic [15:0] magic, len, crc;
		logic [7:0]  ver, typ;
		logic [31:0] seq_no;
		logic [7:0]  body [$];
		frame_kind_t kind;
		pick = $urandom_range(0, 99);
		if (pick < 55) kind = KIND_GOOD;
		else if (pick < 60) kind = KIND_SHORT_HDR;
		else if (pick < 65) kind = KIND_MAGIC;
		else if (pick < 70) kind = KIND_VERSION;
		else if (pick < 75) kind = KIND_TYPE;
		else if (pick < 83) kind = KIND_LENGTH;
		else if (pick < 88) kind = KIND_SHORT_PAY;
		else if (pick < 95) kind = KIND_CRC;
		else kind = KIND_NOISE;

		frame_bytes.delete();
		if (kind == KIND_NOISE) begin
			repeat ($urandom_range(1, 24)) frame_bytes.push_back(8'($urandom));
			return;
		end

		lim    = (32'(cfg_maxlen) < fdc_pkg::MAX_PAYLOAD) ? 32'(cfg_maxlen)
			: fdc_pkg::MAX_PAYLOAD;
		plen   = ($urandom_range(0, 7) == 0) ? lim : $urandom_range(0, (lim < 8) ? lim : 8);
		magic  = cfg_magic;
		ver    = cfg_version;
		typ    = 8'($urandom_range(32'(fdc_pkg::TYPE_MIN), 32'(fdc_pkg::TYPE_MAX)));
		seq_no = $urandom;
		unique case (kind)
			KIND_MAGIC:   magic = magic ^ 16'($urandom_range(1, 16'hFFFF));
			KIND_VERSION: ver = ver ^ 8'($urandom_range(1, 8'hFF));
			KIND_TYPE:    typ = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(7, 255));
			KIND_LENGTH:
				plen = ($urandom_range(0, 3) == 0) ? $urandom_range(lim + 1, 16'hFFFF)
				                                   : $urandom_range(lim + 1, 40);
			default: ;
		endcase
		nbody = (plen > 40) ? $urandom_range(0, 40) : plen;
		if (kind == KIND_SHORT_PAY && plen > 0) nbody = $urandom_range(0, plen - 1);
		repeat (nbody) body.push_back(8'($urandom));

		crc = fdc_pkg::CRC_INIT;
		foreach (body[j]) crc = crc_step(crc, body[j]);
		if (plen == 0) crc = 16'h0000;
		if (kind == KIND_CRC) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
		len = 16'(plen);

		frame_bytes = '{magic[7:0], magic[15:8], ver, typ, len[7:0], len[15:8],
			seq_no[7:0], seq_no[15:8], seq_no[23:16], seq_no[31:24], crc[7:0], crc[15:8]};
		if (kind == KIND_SHORT_HDR) begin
			i = $urandom_range(1, 11);
			while (frame_bytes.size() > i) void'(frame_bytes.pop_back());
			return;
		end
		foreach (body[j]) frame_bytes.push_back(body[j]);
		// trailing bytes beyond the frame are dropped by the block
		if (kind == KIND_GOOD && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
	endtask

	task automatic run_phase(input logic [15:0] magic, input logic [15:0] ver,
		input logic [15:0] maxlen, input int unsigned n_items);
		int unsigned sent;
		write_reg(fdc_pkg::REG_MAGIC, magic);
		write_reg(fdc_pkg::REG_VERSION, ver);
		write_reg(fdc_pkg::REG_MAXLEN, maxlen);
		sent = 0;
		while (sent < n_items) begin
			build_frame();
			send_frame();
			sent += frame_bytes.size();
		end
		settle();
	endtask

	// result side: random stalls, plus one long hold-off on request
	always begin : result_sink
		int unsigned stall;
		@(posedge clk);
		if (hold_results) begin
			hold_results = 1'b0;
			res_ch.ready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			res_ch.ready <= 1'b1;
		end else if (gaps_on && $urandom_range(0, 7) == 0) begin
			stall = $urandom_range(1, 12);
			res_ch.ready <= 1'b0;
			repeat (stall) @(posedge clk);
			res_ch.ready <= 1'b1;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// a beat seen here is taken at the next rising edge
	always @(negedge clk) begin : result_check
		fdc_pkg::result_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (results_due.size() == 0) begin
				report("beat with none due", 32'(res_ch.status), 32'(0));
			end else begin
				want = results_due.pop_front();
				if (res_ch.status !== want.status)
					report("status", 32'(res_ch.status), 32'(want.status));
				if (res_ch.msg_type !== want.msg_type)
					report("msg_type", 32'(res_ch.msg_type), 32'(want.msg_type));
				if (res_ch.sequence_res !== want.sequence_res)
					report("sequence_res", res_ch.sequence_res, want.sequence_res);
				if (res_ch.pay_len !== want.pay_len)
					report("pay_len", 32'(res_ch.pay_len), 32'(want.pay_len));
				if (res_ch.frame_total !== want.frame_total)
					report("frame_total", 32'(res_ch.frame_total), 32'(want.frame_total));
				if (res_ch.payload_byte !== want.payload_byte)
					report("payload_byte", 32'(res_ch.payload_byte), 32'(want.payload_byte));
				if (res_ch.run_last !== want.run_last)
					report("run_last", 32'(res_ch.run_last), 32'(want.run_last));
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if (arst_n !== 1'b1 || (rx_ch.valid && rx_ch.ready) ||
				(res_ch.valid && res_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int unsigned      i, made;
		fdc_pkg::result_t ok_empty;

		arst_n           <= 1'b0;
		rx_ch.valid      <= 1'b0;
		rx_ch.data_byte  <= 8'h00;
		rx_ch.buffer_end <= 1'b0;
		res_ch.ready     <= 1'b0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= fdc_pkg::REG_MAGIC;
		cfg_ch.data      <= 16'h0000;
		cfg_magic   = 16'h0000;
		cfg_version = 8'h00;
		cfg_maxlen  = 6'(fdc_pkg::MAX_PAYLOAD);
		clear_frame_state();

		ok_empty = '0;
		ok_empty.status       = fdc_pkg::STAT_OK;
		ok_empty.msg_type     = 3'd6;
		ok_empty.sequence_res = 32'hFFFF_FFFF;
		ok_empty.frame_total  = 6'd12;
		ok_empty.run_last     = 1'b1;

		// reset registers: magic 0, version 0, length limit 32
		directed_rows = '{
			end_row(8'hFF, fail_beat(fdc_pkg::STAT_SHORT_HDR)),
			end_row(8'h00, fail_beat(fdc_pkg::STAT_SHORT_HDR)),
			// all-zero header: type 0 is out of range
			mid_row(8'h00), mid_row(8'h00), mid_row(8'h00), mid_row(8'h00),
			mid_row(8'h00), mid_row(8'h00), mid_row(8'h00), mid_row(8'h00),
			mid_row(8'h00), mid_row(8'h00), mid_row(8'h00),
			end_row(8'h00, fail_beat(fdc_pkg::STAT_TYPE)),
			// empty payload, top type, all-ones sequence, stored CRC zero
			mid_row(8'h00), mid_row(8'h00), mid_row(8'h00), mid_row(8'h06),
			mid_row(8'h00), mid_row(8'h00), mid_row(8'hFF), mid_row(8'hFF),
			mid_row(8'hFF), mid_row(8'hFF), mid_row(8'h00),
			end_row(8'h00, ok_empty)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gaps_on = 1'b1;

		for (i = 0; i < directed_rows.size(); i++) begin
			push_byte(directed_rows[i].data_byte, directed_rows[i].buffer_end);
			made = decode_byte(directed_rows[i].data_byte, directed_rows[i].buffer_end);
			if (directed_rows[i].typed) begin
				repeat (made) void'(results_due.pop_back());
				results_due.push_back(directed_rows[i].want);
			end
		end
		settle();

		// output held off at the start so the block backs up into its input
		hold_results = 1'b1;
		run_phase(16'($urandom), 16'($urandom), 16'd32, 90);
		run_phase(16'hFFFF, 16'h00FF, 16'd0, 60);
		write_reg(REG_SPARE, 16'($urandom));
		run_phase(16'h0000, 16'h0000, 16'h003F, 60);
		run_phase(16'($urandom), 16'($urandom),
			{10'($urandom), 6'($urandom_range(1, 31))}, 90);
		gaps_on = 1'b0;
		run_phase(16'($urandom), 16'($urandom), 16'd32, 60);

		if (mismatches == 0 && results_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
